/* design/tmaf_pkg.sv */
package tmaf_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 18;
    localparam int IDX_W    = 6;

    // Numerator after rounding offset can carry one bit past the sum
    localparam int NUM_W       = SUM_W + 1;
    // Reciprocal scale: exact floor division for NUM_W-bit values, divisor below 2**IDX_W
    localparam int RECIP_SHIFT = NUM_W + IDX_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam int BLOCK_SAMPLES_DEF = 10;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SUM_W-1:0]    sum_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [NUM_W-1:0]    num_t;

    localparam sample_t SAMPLE_MAX = '1;

    // Closed block statistics handed from the accumulator to the divider
    typedef struct packed {
        sum_t    sum;
        sample_t max_s;
        sample_t min_s;
    } block_stats_t;

endpackage

/* design/tmaf_accum.sv */
module tmaf_accum
    import tmaf_pkg::*;
#(
    parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  sample_t      s_sample,
    output logic         blk_valid,
    input  logic         blk_ready,
    output block_stats_t blk
);

    localparam int   LastInt  = (BLOCK_SAMPLES > 1) ? BLOCK_SAMPLES - 1 : 0;
    localparam idx_t LAST_IDX = IDX_W'(LastInt);

    idx_t         idx_reg, idx_next;
    sample_t      max_reg, max_next;
    sample_t      min_reg, min_next;
    sum_t         sum_reg, sum_next;
    logic         blk_valid_reg, blk_valid_next;
    block_stats_t blk_reg, blk_next;

    sample_t mx, mn;
    sum_t    sum_new;
    logic    is_last;
    logic    accept;

    // Running statistics including the incoming sample
    assign mx      = (s_sample > max_reg) ? s_sample : max_reg;
    assign mn      = (s_sample < min_reg) ? s_sample : min_reg;
    assign sum_new = sum_reg + SUM_W'(s_sample);
    assign is_last = !(idx_reg < LAST_IDX);

    // Samples inside a block never wait; the closing sample needs the hand-off slot
    assign s_ready = !is_last || !blk_valid_reg || blk_ready;
    assign accept  = s_valid && s_ready;

    // Next state
    always_comb begin
        idx_next       = idx_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        sum_next       = sum_reg;
        blk_next       = blk_reg;
        blk_valid_next = blk_valid_reg && !blk_ready;
        if (accept) begin
            if (is_last) begin
                idx_next       = '0;
                max_next       = '0;
                min_next       = SAMPLE_MAX;
                sum_next       = '0;
                blk_next.sum   = sum_new;
                blk_next.max_s = mx;
                blk_next.min_s = mn;
                blk_valid_next = 1'b1;
            end else begin
                idx_next = idx_reg + idx_t'(1);
                max_next = mx;
                min_next = mn;
                sum_next = sum_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= SAMPLE_MAX;
            sum_reg       <= '0;
            blk_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            sum_reg       <= sum_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
    end

    assign blk_valid = blk_valid_reg;
    assign blk       = blk_reg;

endmodule

/* design/tmaf_divider.sv */
module tmaf_divider
    import tmaf_pkg::*;
#(
    parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         blk_valid,
    output logic         blk_ready,
    input  block_stats_t blk,
    output logic         quot_valid,
    input  logic         quot_ready,
    output num_t         quot
);

    localparam int DIVISOR = (BLOCK_SAMPLES > 2) ? BLOCK_SAMPLES - 2 : 1;
    localparam int HALF    = DIVISOR / 2;
    // ceil(2**RECIP_SHIFT / DIVISOR)
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic num_valid_reg, num_valid_next;
    num_t num_reg, num_next;
    logic quot_valid_reg, quot_valid_next;
    num_t quot_reg, quot_next;

    logic                     num_ready;
    sum_t                     extrema;
    sum_t                     trimmed;
    logic [NUM_W+RECIP_W-1:0] product;

    assign num_ready = !quot_valid_reg || quot_ready;
    assign blk_ready = !num_valid_reg || num_ready;

    // Drop one max and one min, floor at zero, add the rounding offset
    assign extrema = SUM_W'(blk.max_s) + SUM_W'(blk.min_s);
    assign trimmed = (blk.sum >= extrema) ? blk.sum - extrema : '0;

    // Divide by the block divisor via scaled reciprocal
    assign product = (NUM_W+RECIP_W)'(num_reg) * (NUM_W+RECIP_W)'(RECIP);

    always_comb begin
        num_valid_next  = num_valid_reg;
        num_next        = num_reg;
        quot_valid_next = quot_valid_reg;
        quot_next       = quot_reg;
        if (blk_ready) begin
            num_valid_next = blk_valid;
            num_next       = NUM_W'(trimmed) + NUM_W'(HALF);
        end
        if (num_ready) begin
            quot_valid_next = num_valid_reg;
            quot_next       = product[RECIP_SHIFT +: NUM_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_valid_reg  <= 1'b0;
            quot_valid_reg <= 1'b0;
        end else begin
            num_valid_reg  <= num_valid_next;
            quot_valid_reg <= quot_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign quot_valid = quot_valid_reg;
    assign quot       = quot_reg;

endmodule

/* design/trimmed_mean_adc_filter_core.sv */
// Trimmed-mean ADC block filter.
// Input channel (s_valid/s_ready/s_sample): one raw 12-bit ADC sample per request.
// Result channel (m_valid/m_ready/m_average): one 12-bit average per block of
// BLOCK_SAMPLES samples, the rounded-half-up mean of the block with one largest
// and one smallest sample removed.
// Throughput: one sample per cycle. Samples inside a block are always taken at
// once; only the closing sample of a block can wait, when the pipeline behind
// the accumulator is full.
// Path: the edge that takes the closing sample loads the statistics register;
// the trimmed numerator, reciprocal product and output registers follow in
// that order, and m_valid rises with the output register.
// The divide is a constant-reciprocal multiply, one stage.
// Receiver stall: the output register and the two inner stages hold their data;
// the accumulator keeps taking samples and stalls only on a closing sample that
// finds all stages occupied. No request is dropped.
// Reset (aresetn low, synchronous): block counter, max, min and sum return to
// their start values and all stage valid flags clear.
module trimmed_mean_adc_filter_core
    import tmaf_pkg::*;
#(
    parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_sample,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_average
);

    logic         blk_valid, blk_ready;
    block_stats_t blk;
    logic         quot_valid, quot_ready;
    num_t         quot;

    logic    m_valid_reg, m_valid_next;
    sample_t avg_reg, avg_next;

    tmaf_accum #(
        .BLOCK_SAMPLES(BLOCK_SAMPLES)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .blk_valid(blk_valid),
        .blk_ready(blk_ready),
        .blk      (blk)
    );

    tmaf_divider #(
        .BLOCK_SAMPLES(BLOCK_SAMPLES)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk),
        .quot_valid(quot_valid),
        .quot_ready(quot_ready),
        .quot      (quot)
    );

    // Output register with saturation to the sample range
    assign quot_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        avg_next     = avg_reg;
        if (quot_ready) begin
            m_valid_next = quot_valid;
            avg_next     = (quot > NUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quot[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg <= avg_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_average = avg_reg;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import tmaf_pkg::*;

    localparam int NSAMP    = BLOCK_SAMPLES_DEF;
    localparam int LAST_IDX = (NSAMP > 1) ? NSAMP - 1 : 0;
    localparam int DIVISOR  = (NSAMP > 2) ? NSAMP - 2 : 1;
    localparam int LONG_HOLD = 500;

    typedef struct {
        sample_t value;
        bit      after_drain;   // hold this request until every average is back
    } feed_item_t;

    logic    aclk     = 1'b0;
    logic    aresetn  = 1'b0;
    logic    s_valid  = 1'b0;
    logic    s_ready;
    sample_t s_sample = '0;
    logic    m_valid;
    logic    m_ready  = 1'b0;
    sample_t m_average;

    feed_item_t feed_q[$];
    sample_t    trim_avg_q[$];
    feed_item_t next_item;

    // Filter state mirrored from the accepted samples
    idx_t    blk_idx = '0;
    sample_t blk_max = '0;
    sample_t blk_min = SAMPLE_MAX;
    sum_t    blk_sum = '0;

    int mismatches   = 0;
    int avg_seen     = 0;
    int next_hold_at = 10;
    int tx_gap       = 0;
    int rx_gap       = 0;
    int hold_left    = 0;
    int tx_gap_pct   = 0;
    int rx_gap_pct   = 0;

    trimmed_mean_adc_filter_core #(
        .BLOCK_SAMPLES(NSAMP)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_average(m_average)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Mostly short gaps, some medium, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Fold one accepted sample into the block; close the block on its last sample
    task automatic absorb_sample(input sample_t s);
        sample_t     hi;
        sample_t     lo;
        sum_t        total;
        int unsigned trimmed;
        int unsigned mean;
        hi    = (s > blk_max) ? s : blk_max;
        lo    = (s < blk_min) ? s : blk_min;
        total = blk_sum + sum_t'(s);
        if (32'(blk_idx) < LAST_IDX) begin
            blk_max = hi;
            blk_min = lo;
            blk_sum = total;
            blk_idx = blk_idx + idx_t'(1);
        end else begin
            // drop one max and one min, then round half up
            if (32'(total) >= 32'(hi) + 32'(lo))
                trimmed = 32'(total) - 32'(hi) - 32'(lo);
            else
                trimmed = 0;
            mean = (trimmed + DIVISOR / 2) / DIVISOR;
            if (mean > 32'(SAMPLE_MAX))
                mean = 32'(SAMPLE_MAX);
            trim_avg_q.push_back(sample_t'(mean));
            blk_idx = '0;
            blk_max = '0;
            blk_min = SAMPLE_MAX;
            blk_sum = '0;
        end
    endtask

    // One block of samples in a given shape
    task automatic queue_block(input int shape, input bit after_drain);
        sample_t    base;
        feed_item_t it;
        int         r;
        base = sample_t'($urandom_range(0, 4095));
        for (int k = 0; k < NSAMP; k++) begin
            case (shape)
                0: begin
                    it.value = sample_t'($urandom_range(0, 4095));
                end
                1: begin
                    // narrow band: many ties and varied remainders
                    if (base > 12'd4091)
                        it.value = base - sample_t'($urandom_range(0, 3));
                    else
                        it.value = base + sample_t'($urandom_range(0, 3));
                end
                2: begin
                    it.value = base;
                end
                default: begin
                    r = $urandom_range(0, 2);
                    if (r == 0)
                        it.value = '0;
                    else if (r == 1)
                        it.value = SAMPLE_MAX;
                    else
                        it.value = sample_t'($urandom_range(0, 4095));
                end
            endcase
            it.after_drain = after_drain && (k == 0);
            feed_q.push_back(it);
        end
    endtask

    task automatic queue_random_blocks(input int count, input bit drain_first);
        int r;
        for (int b = 0; b < count; b++) begin
            r = $urandom_range(0, 9);
            if (r < 5)
                queue_block(0, drain_first && b == 0);
            else if (r < 7)
                queue_block(1, drain_first && b == 0);
            else if (r < 8)
                queue_block(2, drain_first && b == 0);
            else
                queue_block(3, drain_first && b == 0);
        end
    endtask

    task automatic wait_feed_empty();
        while (feed_q.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    // Sample driver: takes requests from feed_q, inserts idle gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready)
                absorb_sample(s_sample);
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (feed_q.size() != 0 &&
                             !(feed_q[0].after_drain && trim_avg_q.size() != 0)) begin
                    next_item = feed_q.pop_front();
                    s_valid   <= 1'b1;
                    s_sample  <= next_item.value;
                    tx_gap    <= ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random ready gaps plus occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_gap    <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (avg_seen == next_hold_at) begin
            hold_left    <= LONG_HOLD;
            next_hold_at <= next_hold_at + 40;
            m_ready      <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_gap  <= ($urandom_range(0, 99) < rx_gap_pct) ? pick_gap() : 0;
        end
    end

    // Result monitor: compare each average with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            avg_seen <= avg_seen + 1;
            if (trim_avg_q.size() == 0) begin
                report_mismatch($sformatf("average %0d with no block closed", m_average));
            end else begin
                if (m_average !== trim_avg_q[0])
                    report_mismatch($sformatf("average got %0d want %0d",
                                              m_average, trim_avg_q[0]));
                void'(trim_avg_q.pop_front());
            end
        end
    end

    // Stimulus sequence
    initial begin
        sample_t    dir_samples[2*NSAMP];
        feed_item_t it;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: both field extremes, repeated max, a round-half-up case
        for (int k = 0; k < NSAMP; k++)
            dir_samples[k] = (k == 0) ? sample_t'(0) : SAMPLE_MAX;
        for (int k = 0; k < NSAMP; k++)
            dir_samples[NSAMP + k] = '0;
        dir_samples[NSAMP + 4]         = 12'd4;
        dir_samples[NSAMP + NSAMP - 2] = SAMPLE_MAX;
        for (int k = 0; k < 2 * NSAMP; k++) begin
            it.value       = dir_samples[k];
            it.after_drain = 1'b0;
            feed_q.push_back(it);
        end
        wait_feed_empty();

        // Random, moderate idling on both sides; sender first waits for a full drain
        tx_gap_pct = 25;
        rx_gap_pct = 25;
        queue_random_blocks(36, 1'b1);
        wait_feed_empty();

        // Random, back to back on both sides
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        queue_random_blocks(36, 1'b0);
        wait_feed_empty();

        // Random, heavy idling, again after a full drain
        tx_gap_pct = 50;
        rx_gap_pct = 50;
        queue_random_blocks(36, 1'b1);
        wait_feed_empty();

        while (trim_avg_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
